/* sv/cshnt_pkg.sv */
package cshnt_pkg;

  // default sizing
  localparam int MAX_HOPS_DEF  = 16;
  localparam int FACE_BITS_DEF = 16;

  // field widths of the words on the ports
  localparam int FACE_W  = 16;
  localparam int COST_W  = 64;
  localparam int RANK_W  = 4;
  localparam int POS_W   = 4;
  localparam int COUNT_W = 5;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_UPDATED   = 3'd0,
    ST_ADDED     = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_PRESENT   = 3'd5,
    ST_READ_OK   = 3'd6
  } status_t;

  typedef struct packed {
    action_t             action;
    logic [FACE_W-1:0]   face_id;
    logic [COST_W-1:0]   hop_cost;
    logic [RANK_W-1:0]   rank;
  } in_word_t;

  typedef struct packed {
    status_t             status;
    logic [POS_W-1:0]    position;
    logic [FACE_W-1:0]   out_face_id;
    logic [COST_W-1:0]   out_cost;
    logic [COUNT_W-1:0]  entry_count;
  } out_word_t;

endpackage

/* sv/cost_sorted_next_hop_table_core.sv */
// Read at rank: the RAM read issues on accept and S_RDWAIT gives the strobe; a rank past
// the count is answered from S_IDLE and busy never rises. Query, add/update, remove sweep
// one entry per cycle on the single RAM read port; S_DECIDE gives the strobe. Changes then
// move entries one per cycle (read, write back next cycle) in S_SHIFT while busy stays high.
// Reset clears the entry count and control; the entry RAM is not cleared.
// Results are single-cycle strobes; the receiver cannot stall.
module cost_sorted_next_hop_table_core #(
  parameter int MAX_HOPS  = cshnt_pkg::MAX_HOPS_DEF,
  parameter int FACE_BITS = cshnt_pkg::FACE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  cshnt_pkg::in_word_t  in_word,
  output logic                 out_valid,
  output cshnt_pkg::out_word_t out_word
);
  import cshnt_pkg::*;

  localparam int AW = $clog2(MAX_HOPS);
  localparam int CW = $clog2(MAX_HOPS + 1);
  localparam int RW = (CW > RANK_W) ? CW : RANK_W;
  localparam int FW = (FACE_BITS < FACE_W) ? FACE_BITS : FACE_W;
  localparam int DW = FW + COST_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_RDWAIT,
    S_SHIFT
  } state_t;

  state_t             state_r;
  logic [CW-1:0]      count_r;
  action_t            act_r;
  logic [FW-1:0]      face_r;
  logic [COST_W-1:0]  cost_r;
  logic [RANK_W-1:0]  rank_r;

  // sweep
  logic [CW-1:0]      sa_r;
  logic               found_r;
  logic [AW-1:0]      idx_r;
  logic [CW-1:0]      le_r;
  logic [COST_W-1:0]  hit_cost_r;

  // shift engine
  logic               up_r;
  logic [AW-1:0]      sh_r;
  logic [CW-1:0]      mv_r;
  logic               pend_r;
  logic [AW-1:0]      pend_addr_r;
  logic               ins_r;
  logic [AW-1:0]      pos_r;

  logic               out_valid_r;
  out_word_t          out_word_r;

  // RAM ports
  logic               ram_wr_en;
  logic [AW-1:0]      ram_wr_addr;
  logic [DW-1:0]      ram_wr_data;
  logic               ram_rd_en;
  logic [AW-1:0]      ram_rd_addr;
  logic [DW-1:0]      ram_rd_data;

  logic [FW-1:0]      rd_face;
  logic [COST_W-1:0]  rd_cost;
  logic [RW-1:0]      rank_ext;
  logic [RW-1:0]      cnt_ext;
  logic               rank_ok;
  logic               accept;
  logic               full;
  logic [CW-1:0]      idx_ext;
  logic [CW-1:0]      sa_last;

  // outcome of the sweep, loaded in S_DECIDE
  out_word_t          dec_word;
  logic [CW-1:0]      dec_count;
  logic               dec_shift;
  logic               dec_up;
  logic [AW-1:0]      dec_sh;
  logic [CW-1:0]      dec_mv;
  logic               dec_ins;

  assign rd_face  = ram_rd_data[DW-1:COST_W];
  assign rd_cost  = ram_rd_data[COST_W-1:0];
  assign rank_ext = RW'(in_word.rank);
  assign cnt_ext  = RW'(count_r);
  assign rank_ok  = rank_ext < cnt_ext;
  assign accept   = start && (state_r == S_IDLE);
  assign full     = count_r == CW'(MAX_HOPS);
  assign idx_ext  = CW'(idx_r);
  assign sa_last  = sa_r - CW'(1);

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  cshnt_entry_ram #(
    .DEPTH (MAX_HOPS),
    .DW    (DW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // RAM access selection
  always_comb begin
    ram_rd_en   = 1'b0;
    ram_rd_addr = '0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = pend_addr_r;
    ram_wr_data = ram_rd_data;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_word.action == ACT_READ) begin
            ram_rd_en   = rank_ok;
            ram_rd_addr = rank_ext[AW-1:0];
          end else begin
            ram_rd_en   = count_r != '0;
            ram_rd_addr = '0;
          end
        end
      end
      S_SCAN: begin
        ram_rd_en   = sa_r < count_r;
        ram_rd_addr = sa_r[AW-1:0];
      end
      S_SHIFT: begin
        ram_rd_en   = mv_r != '0;
        ram_rd_addr = sh_r;
        if (pend_r) begin
          ram_wr_en = 1'b1;
        end else if (mv_r == '0 && ins_r) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = pos_r;
          ram_wr_data = {face_r, cost_r};
        end
      end
      default: begin
      end
    endcase
  end

  // result word and move plan once the sweep is done
  always_comb begin
    dec_word.status      = ST_NOT_FOUND;
    dec_word.position    = '0;
    dec_word.out_face_id = FACE_W'(face_r);
    dec_word.out_cost    = '0;
    dec_word.entry_count = COUNT_W'(count_r);
    dec_count = count_r;
    dec_shift = 1'b0;
    dec_up    = 1'b0;
    dec_sh    = idx_r + AW'(1);
    dec_mv    = '0;
    dec_ins   = 1'b0;
    case (act_r)
      ACT_QUERY: begin
        if (found_r) begin
          dec_word.status   = ST_PRESENT;
          dec_word.position = POS_W'(idx_r);
          dec_word.out_cost = hit_cost_r;
        end
      end
      ACT_REMOVE: begin
        if (found_r) begin
          dec_word.status      = ST_REMOVED;
          dec_word.position    = POS_W'(idx_r);
          dec_word.out_cost    = hit_cost_r;
          dec_word.entry_count = COUNT_W'(count_r - CW'(1));
          dec_count = count_r - CW'(1);
          // close the gap: move idx+1..count-1 down by one
          dec_shift = 1'b1;
          dec_mv    = count_r - CW'(1) - idx_ext;
        end
      end
      ACT_ADD: begin
        if (found_r) begin
          dec_word.status   = ST_UPDATED;
          dec_word.position = POS_W'(le_r);
          dec_word.out_cost = cost_r;
          dec_shift = 1'b1;
          dec_ins   = 1'b1;
          if (le_r >= idx_ext) begin
            // entry moves toward the tail
            dec_mv = le_r - idx_ext;
          end else begin
            // entry moves toward the head
            dec_up = 1'b1;
            dec_sh = idx_r - AW'(1);
            dec_mv = idx_ext - le_r;
          end
        end else if (full) begin
          dec_word.status = ST_FULL;
        end else begin
          dec_word.status      = ST_ADDED;
          dec_word.position    = POS_W'(le_r);
          dec_word.out_cost    = cost_r;
          dec_word.entry_count = COUNT_W'(count_r + CW'(1));
          dec_count = count_r + CW'(1);
          // open a slot: move le..count-1 up by one
          dec_shift = 1'b1;
          dec_up    = 1'b1;
          dec_sh    = sa_last[AW-1:0];
          dec_mv    = count_r - le_r;
          dec_ins   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      mv_r        <= '0;
      ins_r       <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          // only a read past the end answers straight away
          out_valid_r <= accept && (in_word.action == ACT_READ) && !rank_ok;
          if (accept) begin
            act_r   <= in_word.action;
            face_r  <= in_word.face_id[FW-1:0];
            cost_r  <= in_word.hop_cost;
            rank_r  <= in_word.rank;
            sa_r    <= CW'(1);
            found_r <= 1'b0;
            idx_r   <= '0;
            le_r    <= '0;
            hit_cost_r <= '0;
            if (in_word.action == ACT_READ) begin
              if (rank_ok) begin
                state_r <= S_RDWAIT;
              end else begin
                // rank past the end
                out_word_r.status      <= ST_NOT_FOUND;
                out_word_r.position    <= in_word.rank;
                out_word_r.out_face_id <= '0;
                out_word_r.out_cost    <= '0;
                out_word_r.entry_count <= COUNT_W'(count_r);
              end
            end else if (count_r == '0) begin
              state_r <= S_DECIDE;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          out_valid_r <= 1'b0;
          // entry sa_r-1 is on the read data
          if (rd_face == face_r && !found_r) begin
            found_r    <= 1'b1;
            idx_r      <= sa_last[AW-1:0];
            hit_cost_r <= rd_cost;
          end else if (rd_cost <= cost_r) begin
            le_r <= le_r + CW'(1);
          end
          if (sa_r < count_r) begin
            sa_r <= sa_r + CW'(1);
          end else begin
            state_r <= S_DECIDE;
          end
        end

        S_RDWAIT: begin
          out_valid_r            <= 1'b1;
          out_word_r.status      <= ST_READ_OK;
          out_word_r.position    <= rank_r;
          out_word_r.out_face_id <= FACE_W'(rd_face);
          out_word_r.out_cost    <= rd_cost;
          out_word_r.entry_count <= COUNT_W'(count_r);
          state_r                <= S_IDLE;
        end

        S_DECIDE: begin
          out_valid_r <= 1'b1;
          out_word_r  <= dec_word;
          count_r     <= dec_count;
          up_r        <= dec_up;
          sh_r        <= dec_sh;
          mv_r        <= dec_mv;
          ins_r       <= dec_ins;
          pend_r      <= 1'b0;
          pos_r       <= le_r[AW-1:0];
          state_r     <= dec_shift ? S_SHIFT : S_IDLE;
        end

        S_SHIFT: begin
          out_valid_r <= 1'b0;
          // one read per cycle, written back one slot over on the next cycle
          if (mv_r != '0) begin
            mv_r        <= mv_r - CW'(1);
            pend_r      <= 1'b1;
            sh_r        <= up_r ? sh_r - AW'(1) : sh_r + AW'(1);
            pend_addr_r <= up_r ? sh_r + AW'(1) : sh_r - AW'(1);
          end else begin
            pend_r <= 1'b0;
            if (!pend_r) begin
              ins_r   <= 1'b0;
              state_r <= S_IDLE;
            end
          end
        end

        default: begin
          out_valid_r <= 1'b0;
          state_r     <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/cshnt_entry_ram.sv */
module cshnt_entry_ram #(
  parameter int DEPTH = 16,
  parameter int DW    = 80
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DW-1:0]            wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DW-1:0]            rd_data
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
